// ===== hw/rtl/wsfd_pkg.sv =====
// wsfd_pkg: shared types and constants of the websocket frame deframer
// no dependencies; used by wsfd_parser, wsfd_out_buf and the top level
package wsfd_pkg;

    typedef enum logic [4:0] {
        PH_HDR0   = 5'b00001,
        PH_HDR1   = 5'b00010,
        PH_EXTLEN = 5'b00100,
        PH_KEY    = 5'b01000,
        PH_BODY   = 5'b10000
    } phase_t;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    localparam int TDATA_W = 88;

    typedef struct packed {
        logic        kind;
        logic        fin;
        logic [2:0]  rsv;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] payload_length;
        logic [7:0]  data;
        logic        last;
    } rec_t;

endpackage

// ===== hw/rtl/wsfd_parser.sv =====
// wsfd_parser: input beat register and one-pass frame header / payload parser
// depends on wsfd_pkg
module wsfd_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              space,
    output logic              res_valid,
    output wsfd_pkg::rec_t    res
);

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                step;

    wsfd_pkg::phase_t    phase_reg, phase_next;
    logic [7:0]          first_reg, first_next;
    logic                mask_reg, mask_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [63:0]         len_reg, len_next;
    logic [31:0]         key_reg, key_next;
    logic [63:0]         rem_reg, rem_next;
    logic [1:0]          kidx_reg, kidx_next;

    logic                emit;
    logic                body;
    logic [6:0]          code;
    logic [1:0]          kpos;
    logic [7:0]          dout;
    logic                last_c;

    assign step     = in_valid_reg && space;
    assign in_ready = !in_valid_reg || space;
    assign code     = in_byte_reg[6:0];
    assign kpos     = 2'd0 - cnt_reg[1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= in_byte;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        first_next = first_reg;
        mask_next  = mask_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        key_next   = key_reg;
        rem_next   = rem_reg;
        kidx_next  = kidx_reg;
        emit       = 1'b0;
        body       = 1'b0;
        dout       = 8'd0;
        last_c     = 1'b0;
        case (phase_reg)
            wsfd_pkg::PH_HDR1:
            begin
                mask_next = in_byte_reg[7];
                key_next  = 32'd0;
                if (code == wsfd_pkg::LEN_CODE_16 || code == wsfd_pkg::LEN_CODE_64)
                begin
                    len_next   = 64'd0;
                    cnt_next   = (code == wsfd_pkg::LEN_CODE_16) ? wsfd_pkg::EXT16_BYTES
                                                                 : wsfd_pkg::EXT64_BYTES;
                    phase_next = wsfd_pkg::PH_EXTLEN;
                end
                else
                begin
                    len_next = {57'd0, code};
                    if (in_byte_reg[7])
                    begin
                        cnt_next   = wsfd_pkg::KEY_BYTES;
                        phase_next = wsfd_pkg::PH_KEY;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
            end
            wsfd_pkg::PH_EXTLEN:
            begin
                len_next = {len_reg[55:0], in_byte_reg};
                cnt_next = cnt_reg - 4'd1;
                if (cnt_next == 4'd0)
                begin
                    if (mask_reg)
                    begin
                        cnt_next   = wsfd_pkg::KEY_BYTES;
                        phase_next = wsfd_pkg::PH_KEY;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
            end
            wsfd_pkg::PH_KEY:
            begin
                key_next[8*kpos +: 8] = key_reg[8*kpos +: 8] | in_byte_reg;
                cnt_next = cnt_reg - 4'd1;
                if (cnt_next == 4'd0)
                begin
                    emit = 1'b1;
                end
            end
            wsfd_pkg::PH_BODY:
            begin
                body      = 1'b1;
                dout      = mask_reg ? (in_byte_reg ^ key_reg[8*kidx_reg +: 8]) : in_byte_reg;
                last_c    = (rem_reg == 64'd1);
                rem_next  = rem_reg - 64'd1;
                kidx_next = kidx_reg + 2'd1;
                if (last_c)
                begin
                    phase_next = wsfd_pkg::PH_HDR0;
                end
            end
            default:
            begin
                first_next = in_byte_reg;
                phase_next = wsfd_pkg::PH_HDR1;
            end
        endcase
        if (emit)
        begin
            if (len_next == 64'd0)
            begin
                last_c     = 1'b1;
                phase_next = wsfd_pkg::PH_HDR0;
            end
            else
            begin
                rem_next   = len_next;
                kidx_next  = 2'd0;
                phase_next = wsfd_pkg::PH_BODY;
            end
        end
    end

    assign res_valid          = step && (emit || body);
    assign res.kind           = body ? wsfd_pkg::KIND_PAYLOAD : wsfd_pkg::KIND_HEADER;
    assign res.fin            = first_next[7];
    assign res.rsv            = first_next[6:4];
    assign res.opcode         = first_next[3:0];
    assign res.masked         = mask_next;
    assign res.payload_length = len_next;
    assign res.data           = dout;
    assign res.last           = last_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= wsfd_pkg::PH_HDR0;
            first_reg <= 8'd0;
            mask_reg  <= 1'b0;
            cnt_reg   <= 4'd0;
            len_reg   <= 64'd0;
            key_reg   <= 32'd0;
            rem_reg   <= 64'd0;
            kidx_reg  <= 2'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            first_reg <= first_next;
            mask_reg  <= mask_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            key_reg   <= key_next;
            rem_reg   <= rem_next;
            kidx_reg  <= kidx_next;
        end
    end

    a_body_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == wsfd_pkg::PH_BODY |-> rem_reg != 64'd0)
        else $error("body phase with no payload bytes left");

    a_last_byte_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == wsfd_pkg::PH_BODY && rem_reg == 64'd1
        |=> phase_reg == wsfd_pkg::PH_HDR0)
        else $error("frame did not end after last payload byte");

    a_hdr0_to_hdr1: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == wsfd_pkg::PH_HDR0 |=> phase_reg == wsfd_pkg::PH_HDR1)
        else $error("header byte 0 not followed by header byte 1 phase");

    a_no_result_without_space: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> space)
        else $error("result produced with output buffer full");

    a_key_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == wsfd_pkg::PH_KEY |-> (cnt_reg != 4'd0 && cnt_reg <= wsfd_pkg::KEY_BYTES))
        else $error("key byte count out of range");

endmodule

// ===== hw/rtl/wsfd_out_buf.sv =====
// wsfd_out_buf: two-entry result buffer between the parser and the output port
// depends on wsfd_pkg
module wsfd_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    input  wsfd_pkg::rec_t    wr_rec,
    output logic              space,
    output logic              rd_valid,
    input  logic              rd_ready,
    output wsfd_pkg::rec_t    rd_rec
);

    wsfd_pkg::rec_t    slot_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg, count_next;
    logic              pop;

    assign space    = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_rec   = slot_reg[rd_ptr_reg];
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        count_next = count_reg;
        if (wr_valid && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!wr_valid && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid)
        begin
            slot_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_valid)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/websocket_frame_deframer_core.sv =====
// a result beat passes through the input beat register and then a result buffer slot before it is offered
// throughput: one input beat per cycle while the result buffer has space, set by the single-pass parser step
// header byte 0 and unfinished extended-length or key bytes give no result beat
// a two-entry result buffer decouples m_axis_tready from s_axis_tready
// reset (rst_n low, asynchronous) empties both stages and waits for header byte 0
// top level: instantiates wsfd_parser and wsfd_out_buf, uses wsfd_pkg
module websocket_frame_deframer_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // stream_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // fin, rsv, opcode, masked, payload_length, data, zero fill
    output logic [wsfd_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tuser,   // kind
    output logic                          m_axis_tlast
);

    logic              space;
    logic              res_valid;
    wsfd_pkg::rec_t    res;
    wsfd_pkg::rec_t    out_rec;

    wsfd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .space     (space),
        .res_valid (res_valid),
        .res       (res)
    );

    wsfd_out_buf u_out_buf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (res_valid),
        .wr_rec   (res),
        .space    (space),
        .rd_valid (m_axis_tvalid),
        .rd_ready (m_axis_tready),
        .rd_rec   (out_rec)
    );

    assign m_axis_tdata = {7'd0, out_rec.data, out_rec.payload_length, out_rec.masked,
                           out_rec.opcode, out_rec.rsv, out_rec.fin};
    assign m_axis_tuser = out_rec.kind;
    assign m_axis_tlast = out_rec.last;

endmodule
